// File: rtl/hover_thrust_scalar_ekf_defines.svh
// ----------------------------------------------------------------------------
// hover thrust estimator assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HOVER_THRUST_SCALAR_EKF_DEFINES_SVH
`define HOVER_THRUST_SCALAR_EKF_DEFINES_SVH

// condition that holds at every edge out of reset
`define HTEKF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define HTEKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/htekf_pkg.sv
// ----------------------------------------------------------------------------
// htekf_pkg
// constants and unit request types of the hover thrust estimator
// ----------------------------------------------------------------------------
`default_nettype none

package htekf_pkg;

    localparam int MUL_W     = 64;
    localparam int DIV_NUM_W = 76;
    localparam int DIV_DEN_W = 55;
    localparam int DIV_CNT_W = 7;
    localparam int DIV_Q_W   = 64;

    localparam logic [19:0] G_Q16     = 20'd642689;
    localparam logic [15:0] HOVER_MIN = 16'd6554;
    localparam logic [15:0] HOVER_MAX = 16'd52429;
    localparam logic [48:0] VAR_MIN   = 49'd28147;
    localparam logic [48:0] VAR_MAX   = 49'h1_0000_0000_0000;
    localparam logic [27:0] NOISE_MIN = 28'd1678;
    localparam logic [27:0] NOISE_MAX = 28'd167772160;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    // floor(x / 15625) as (x * INC_RECIP) >> INC_SHIFT, exact for x below 2^59
    localparam logic [59:0] INC_RECIP = 60'd604462909807314588;
    localparam int          INC_SHIFT = 73;
    localparam logic [9:0]  US_PER_MS = 10'd1000;

    localparam logic [31:0] Q_RESET     = 32'd55661;
    localparam logic [15:0] GATE_RESET  = 16'd12288;
    localparam logic [16:0] TAU_RESET   = 17'd2000;
    localparam logic [15:0] HOVER_RESET = 16'd32768;
    localparam logic [48:0] VAR_RESET   = 49'd11258999068426;
    localparam logic [27:0] NOISE_RESET = 28'd4194304;

    localparam logic [1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [1:0] CFG_GATE_SIZE     = 2'd1;
    localparam logic [1:0] CFG_NOISE_TAU     = 2'd2;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_CNT_W-1:0] nbits;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

// File: rtl/htekf_mul.sv
// ----------------------------------------------------------------------------
// htekf_mul
// 64x64 unsigned multiplier built from four 32x32 partial products
// ----------------------------------------------------------------------------
`default_nettype none

module htekf_mul
    import htekf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic [2*MUL_W-1:0] prod
);

    localparam int HALF = MUL_W / 2;

    logic               busy_reg, busy_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [MUL_W-1:0]   a_reg, a_next;
    logic [MUL_W-1:0]   b_reg, b_next;
    logic [MUL_W-1:0]   pp_reg, pp_next;
    logic [1:0]         sh_reg, sh_next;
    logic [2*MUL_W-1:0] acc_reg, acc_next;
    logic [HALF-1:0]    a_half;
    logic [HALF-1:0]    b_half;
    logic [2*MUL_W-1:0] pp_wide;

    always_comb
    begin
        a_half    = cnt_reg[1] ? a_reg[MUL_W-1:HALF] : a_reg[HALF-1:0];
        b_half    = cnt_reg[0] ? b_reg[MUL_W-1:HALF] : b_reg[HALF-1:0];
        pp_wide   = {{MUL_W{1'b0}}, pp_reg} << (HALF * int'(sh_reg));
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // partial product registered, accumulated in the next cycle
            pp_next  = {{HALF{1'b0}}, a_half} * {{HALF{1'b0}}, b_half};
            sh_next  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            if (cnt_reg != 3'd0)
            begin
                acc_next = acc_reg + pp_wide;
            end
            cnt_next = 3'(cnt_reg + 3'd1);
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// File: rtl/htekf_div.sv
// ----------------------------------------------------------------------------
// htekf_div
// restoring divider, one quotient bit per cycle, variable dividend length
// ----------------------------------------------------------------------------
`default_nettype none

module htekf_div
    import htekf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic [DIV_Q_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   quot_reg, quot_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        rem_sub   = rem_sh - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            // left-align the dividend so its top bit enters first
            num_next  = req.num << (DIV_NUM_W - int'(req.nbits));
            den_next  = req.den;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quot_next = {quot_reg[DIV_Q_W-2:0], ge};
            num_next  = {num_reg[DIV_NUM_W-2:0], 1'b0};
            cnt_next  = DIV_CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/hover_thrust_scalar_ekf.sv
// ----------------------------------------------------------------------------
// hover_thrust_scalar_ekf
// one-state kalman filter for hover thrust with adaptive measurement noise
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_ready    | mode, dt_us, acc_z, thrust
//  out     | out_valid / out_ready  | hover_thrust, thrust_variance,
//          |                        | measurement_noise, innovation, gate_passed
//
//  a predict transaction runs two multiplies from accept to result, a fuse runs
//  longer when the gate passes than when it rejects, and PH_DONE returns to
//  PH_IDLE before the next accept
//  the one-bit-per-cycle divider (four quotients per fuse, five on a pass) sets
//  most of the run time, each pass through the shared multiplier the rest
//  in_ready is high only while the sequencer is idle; one result waits in the
//  output register while the next transaction is taken
//  reset restores the register defaults and the filter state, no sweep needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "hover_thrust_scalar_ekf_defines.svh"

module hover_thrust_scalar_ekf
    import htekf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [16:0] dt_us,
    input  logic [23:0] acc_z,
    input  logic [15:0] thrust,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] hover_thrust,
    output logic [48:0] thrust_variance,
    output logic [27:0] measurement_noise,
    output logic [23:0] innovation,
    output logic        gate_passed
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ISSUE = 4'b0010,
        PH_WAIT  = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    localparam logic [4:0] PC_P_QDT   = 5'd0;
    localparam logic [4:0] PC_P_INC   = 5'd1;
    localparam logic [4:0] PC_F_GT    = 5'd2;
    localparam logic [4:0] PC_F_HH    = 5'd3;
    localparam logic [4:0] PC_F_HM    = 5'd4;
    localparam logic [4:0] PC_F_PRED  = 5'd5;
    localparam logic [4:0] PC_F_HM2   = 5'd6;
    localparam logic [4:0] PC_F_HPH   = 5'd7;
    localparam logic [4:0] PC_F_PHM   = 5'd8;
    localparam logic [4:0] PC_F_KM    = 5'd9;
    localparam logic [4:0] PC_F_SQ    = 5'd10;
    localparam logic [4:0] PC_F_GG    = 5'd11;
    localparam logic [4:0] PC_F_GATE  = 5'd12;
    localparam logic [4:0] PC_F_DELTA = 5'd13;
    localparam logic [4:0] PC_F_KH    = 5'd14;
    localparam logic [4:0] PC_F_PUPD  = 5'd15;
    localparam logic [4:0] PC_F_RES   = 5'd16;
    localparam logic [4:0] PC_F_RSQ   = 5'd17;
    localparam logic [4:0] PC_R_DEN   = 5'd18;
    localparam logic [4:0] PC_R_ALPHA = 5'd19;
    localparam logic [4:0] PC_R_TGT   = 5'd20;
    localparam logic [4:0] PC_R_OLD   = 5'd21;
    localparam logic [4:0] PC_R_NEW   = 5'd22;

    typedef struct packed {
        logic [16:0] dt;
        logic [23:0] acc;
        logic [15:0] thrust;
        logic [35:0] gt;
        logic [31:0] hh;
        logic [26:0] hm;
        logic [25:0] innov;
        logic [24:0] mag;
        logic [53:0] hm2;
        logic [54:0] s;
        logic [58:0] t;
        logic [56:0] km;
        logic [49:0] sq;
        logic [31:0] gg;
        logic        pass;
        logic [32:0] fac;
        logic [27:0] den;
        logic [32:0] alpha;
        logic [54:0] target;
        logic [36:0] u;
    } work_t;

    typedef struct packed {
        logic [15:0] hover;
        logic [48:0] variance;
        logic [27:0] noise;
        logic [23:0] innov;
        logic        pass;
    } result_t;

    phase_t       phase_reg, phase_next;
    logic [4:0]   pc_reg, pc_next;
    work_t        w_reg, w_next;
    result_t      res_reg, res_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  q_reg, q_next;
    logic [15:0]  gate_reg, gate_next;
    logic [16:0]  tau_reg, tau_next;
    logic [15:0]  hover_reg, hover_next;
    logic [48:0]  p_reg, p_next;
    logic [27:0]  r_reg, r_next;
    logic [16:0]  last_reg, last_next;

    mul_req_t             mul_req;
    logic                 mul_done;
    logic [2*MUL_W-1:0]   mul_prod;
    div_req_t             div_req;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_q;

    logic [25:0]  inn;
    logic [24:0]  inn_mag;
    logic [49:0]  p_sum;
    logic [49:0]  delta;
    logic [16:0]  dsat;
    logic         innov_pos;
    logic [18:0]  hn;
    logic [48:0]  pn;
    logic [56:0]  r32;
    logic [48:0]  r_sh;
    logic         gate_lt;
    logic [23:0]  innov_sat;

    htekf_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .done (mul_done),
        .prod (mul_prod)
    );

    htekf_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quot (div_q)
    );

    // acc - (gt / hover - g), signed 26 bits
    function automatic logic [25:0] innov_of(input logic [23:0] acc, input logic [24:0] q);
        logic [25:0] pred;
        pred = {1'b0, q} - {6'd0, G_Q16};
        return {{2{acc[23]}}, acc} - pred;
    endfunction

    function automatic logic [24:0] mag_of(input logic [25:0] v);
        logic [25:0] neg;
        neg = (~v) + 26'd1;
        return v[25] ? neg[24:0] : v[24:0];
    endfunction

    always_comb
    begin
        inn       = innov_of(w_reg.acc, div_q[24:0]);
        inn_mag   = mag_of(inn);
        // process noise increment q * dt * 1024 / 15625 by reciprocal
        p_sum     = {1'b0, p_reg} + mul_prod[INC_SHIFT +: 50];
        delta     = mul_prod[81:32];
        dsat      = (delta > 50'd65536) ? 17'd65536 : delta[16:0];
        innov_pos = !w_reg.innov[25] && (w_reg.innov != 26'd0);
        hn        = innov_pos ? ({3'b0, hover_reg} - {2'b0, dsat})
                              : ({3'b0, hover_reg} + {2'b0, dsat});
        pn        = mul_prod[80:32];
        r32       = {20'b0, w_reg.u} + {1'b0, mul_prod[87:32]};
        r_sh      = r32[56:8];
        gate_lt   = (mul_prod[127:74] != '0) || ({w_reg.sq, 24'b0} < mul_prod[73:0]);
        if ((w_reg.innov[25:23] == 3'b000) || (w_reg.innov[25:23] == 3'b111))
        begin
            innov_sat = w_reg.innov[23:0];
        end
        else
        begin
            innov_sat = w_reg.innov[25] ? 24'h800000 : 24'h7FFFFF;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pc_next        = pc_reg;
        w_next         = w_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        q_next         = q_reg;
        gate_next      = gate_reg;
        tau_next       = tau_reg;
        hover_next     = hover_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        last_next      = last_reg;
        mul_req        = '0;
        div_req        = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROCESS_NOISE: q_next    = cfg_data;
                CFG_GATE_SIZE:     gate_next = cfg_data[15:0];
                CFG_NOISE_TAU:     tau_next  = cfg_data[16:0];
                default:           ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    w_next.dt     = dt_us;
                    w_next.acc    = acc_z;
                    w_next.thrust = thrust;
                    w_next.innov  = '0;
                    w_next.pass   = 1'b0;
                    pc_next       = mode ? PC_F_GT : PC_P_QDT;
                    phase_next    = PH_ISSUE;
                end
            end
            PH_ISSUE:
            begin
                phase_next = PH_WAIT;
                case (pc_reg)
                    PC_P_QDT:
                    begin
                        mul_req = '{1'b1, MUL_W'(q_reg), MUL_W'(w_reg.dt)};
                    end
                    PC_P_INC:
                    begin
                        mul_req = '{1'b1, MUL_W'({w_reg.t[48:0], 10'b0}), MUL_W'(INC_RECIP)};
                    end
                    PC_F_GT:
                    begin
                        mul_req = '{1'b1, MUL_W'(G_Q16), MUL_W'(w_reg.thrust)};
                    end
                    PC_F_HH:
                    begin
                        mul_req = '{1'b1, MUL_W'(hover_reg), MUL_W'(hover_reg)};
                    end
                    PC_F_HM:
                    begin
                        div_req = '{1'b1, DIV_NUM_W'({w_reg.gt, 16'b0}), DIV_CNT_W'(52),
                                    DIV_DEN_W'(w_reg.hh)};
                    end
                    PC_F_PRED, PC_F_RES:
                    begin
                        div_req = '{1'b1, DIV_NUM_W'(w_reg.gt), DIV_CNT_W'(36),
                                    DIV_DEN_W'(hover_reg)};
                    end
                    PC_F_HM2:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.hm), MUL_W'(w_reg.hm)};
                    end
                    PC_F_HPH, PC_R_TGT:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.hm2), MUL_W'(p_reg)};
                    end
                    PC_F_PHM:
                    begin
                        mul_req = '{1'b1, MUL_W'(p_reg), MUL_W'(w_reg.hm)};
                    end
                    PC_F_KM:
                    begin
                        div_req = '{1'b1, DIV_NUM_W'({w_reg.t, 16'b0}), DIV_CNT_W'(75),
                                    DIV_DEN_W'(w_reg.s)};
                    end
                    PC_F_SQ, PC_F_RSQ:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.mag), MUL_W'(w_reg.mag)};
                    end
                    PC_F_GG:
                    begin
                        mul_req = '{1'b1, MUL_W'(gate_reg), MUL_W'(gate_reg)};
                    end
                    PC_F_GATE:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.gg), MUL_W'(w_reg.s)};
                    end
                    PC_F_DELTA:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.km), MUL_W'(w_reg.mag)};
                    end
                    PC_F_KH:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.km), MUL_W'(w_reg.hm)};
                    end
                    PC_F_PUPD:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.fac), MUL_W'(p_reg)};
                    end
                    PC_R_DEN:
                    begin
                        mul_req = '{1'b1, MUL_W'(tau_reg), MUL_W'(US_PER_MS)};
                    end
                    PC_R_ALPHA:
                    begin
                        div_req = '{1'b1, DIV_NUM_W'({last_reg, 32'b0}), DIV_CNT_W'(49),
                                    DIV_DEN_W'(w_reg.den)};
                    end
                    PC_R_OLD:
                    begin
                        mul_req = '{1'b1, MUL_W'(ONE_Q32 - w_reg.alpha), MUL_W'({r_reg, 8'b0})};
                    end
                    PC_R_NEW:
                    begin
                        mul_req = '{1'b1, MUL_W'(w_reg.alpha), MUL_W'(w_reg.target)};
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
            PH_WAIT:
            begin
                if (mul_done || div_done)
                begin
                    phase_next = PH_ISSUE;
                    pc_next    = 5'(pc_reg + 5'd1);
                    case (pc_reg)
                        PC_P_QDT:   w_next.t = {10'b0, mul_prod[48:0]};
                        PC_P_INC:
                        begin
                            p_next     = (p_sum > {1'b0, VAR_MAX}) ? VAR_MAX : p_sum[48:0];
                            last_next  = w_reg.dt;
                            phase_next = PH_DONE;
                        end
                        PC_F_GT:    w_next.gt = mul_prod[35:0];
                        PC_F_HH:    w_next.hh = mul_prod[31:0];
                        PC_F_HM:    w_next.hm = div_q[26:0];
                        PC_F_PRED:
                        begin
                            w_next.innov = inn;
                            w_next.mag   = inn_mag;
                        end
                        PC_F_HM2:   w_next.hm2 = mul_prod[53:0];
                        PC_F_HPH:
                        begin
                            w_next.s = {1'b0, mul_prod[101:48]} + {19'b0, r_reg, 8'b0};
                        end
                        PC_F_PHM:   w_next.t = mul_prod[74:16];
                        PC_F_KM:    w_next.km = div_q[56:0];
                        PC_F_SQ:    w_next.sq = mul_prod[49:0];
                        PC_F_GG:    w_next.gg = mul_prod[31:0];
                        PC_F_GATE:
                        begin
                            // rejected items keep the innovation as residual
                            w_next.pass = gate_lt;
                            pc_next     = gate_lt ? PC_F_DELTA : PC_R_DEN;
                        end
                        PC_F_DELTA:
                        begin
                            if (hn[18] || (hn < {3'b0, HOVER_MIN}))
                            begin
                                hover_next = HOVER_MIN;
                            end
                            else if (hn > {3'b0, HOVER_MAX})
                            begin
                                hover_next = HOVER_MAX;
                            end
                            else
                            begin
                                hover_next = hn[15:0];
                            end
                        end
                        PC_F_KH:
                        begin
                            // gain times h at or above one zeroes the variance factor
                            w_next.fac = (mul_prod[127:48] != '0) ? 33'd0
                                       : ONE_Q32 - {1'b0, mul_prod[47:16]};
                        end
                        PC_F_PUPD:
                        begin
                            if (pn < VAR_MIN)
                            begin
                                p_next = VAR_MIN;
                            end
                            else if (pn > VAR_MAX)
                            begin
                                p_next = VAR_MAX;
                            end
                            else
                            begin
                                p_next = pn;
                            end
                        end
                        PC_F_RES:   w_next.mag = inn_mag;
                        PC_F_RSQ:   w_next.sq = mul_prod[49:0];
                        PC_R_DEN:   w_next.den = mul_prod[27:0] + {11'b0, last_reg};
                        PC_R_ALPHA:
                        begin
                            w_next.alpha = (w_reg.den == 28'd0) ? 33'd0 : div_q[32:0];
                        end
                        PC_R_TGT:
                        begin
                            w_next.target = {5'b0, w_reg.sq} + {1'b0, mul_prod[101:48]};
                        end
                        PC_R_OLD:   w_next.u = mul_prod[68:32];
                        PC_R_NEW:
                        begin
                            if (r_sh < {21'b0, NOISE_MIN})
                            begin
                                r_next = NOISE_MIN;
                            end
                            else if (r_sh > {21'b0, NOISE_MAX})
                            begin
                                r_next = NOISE_MAX;
                            end
                            else
                            begin
                                r_next = r_sh[27:0];
                            end
                            phase_next = PH_DONE;
                        end
                        default:    phase_next = PH_DONE;
                    endcase
                end
            end
            PH_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.hover    = hover_reg;
                    res_next.variance = p_reg;
                    res_next.noise    = r_reg;
                    res_next.innov    = innov_sat;
                    res_next.pass     = w_reg.pass;
                    out_valid_next    = 1'b1;
                    phase_next        = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pc_reg        <= PC_P_QDT;
            out_valid_reg <= 1'b0;
            q_reg         <= Q_RESET;
            gate_reg      <= GATE_RESET;
            tau_reg       <= TAU_RESET;
            hover_reg     <= HOVER_RESET;
            p_reg         <= VAR_RESET;
            r_reg         <= NOISE_RESET;
            last_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            q_reg         <= q_next;
            gate_reg      <= gate_next;
            tau_reg       <= tau_next;
            hover_reg     <= hover_next;
            p_reg         <= p_next;
            r_reg         <= r_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        res_reg <= res_next;
    end

    assign cfg_ready         = 1'b1;
    assign in_ready          = (phase_reg == PH_IDLE);
    assign out_valid         = out_valid_reg;
    assign hover_thrust      = res_reg.hover;
    assign thrust_variance   = res_reg.variance;
    assign measurement_noise = res_reg.noise;
    assign innovation        = res_reg.innov;
    assign gate_passed       = res_reg.pass;

    `HTEKF_ASSERT_ALWAYS(a_hover_range, (hover_reg >= HOVER_MIN) && (hover_reg <= HOVER_MAX), "hover out of range")
    `HTEKF_ASSERT_ALWAYS(a_var_range, (p_reg >= VAR_MIN) && (p_reg <= VAR_MAX), "variance out of range")
    `HTEKF_ASSERT_ALWAYS(a_noise_range, (r_reg >= NOISE_MIN) && (r_reg <= NOISE_MAX), "noise out of range")
    `HTEKF_ASSERT_ALWAYS(a_one_unit, !(mul_done && div_done), "both units finished together")
    `HTEKF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while working")

endmodule

`default_nettype wire
